FILE: rtl/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Types and constants of the polyline path interpolator.
// ----------------------------------------------------------------------------
package ppi_pkg;

  localparam int CoordW   = 16;
  localparam int TimeW    = 32;
  localparam int FracBits = 24;
  localparam int QuotW    = 32;
  localparam int CoordMax = 2 ** (CoordW - 1) - 1;
  localparam int CoordMin = -CoordMax - 1;

  localparam logic signed [TimeW-1:0] FracOneS  = 32'sh0100_0000;
  localparam logic [TimeW-1:0]        FracMaxU  = 32'h7FFF_FFFF;
  localparam logic [TimeW-1:0]        FracMinU  = 32'h8000_0000;
  localparam logic signed [TimeW-1:0] EndResetS = 32'sh0001_0000;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT    = 2'd0,
    CFG_INTERVAL_START = 2'd1,
    CFG_INTERVAL_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    G_ZERO = 2'd0,
    G_ONE  = 2'd1,
    G_CALC = 2'd2
  } gmode_t;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               point_index;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [TimeW-1:0]  query_time;
    logic                     clip;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } out_item_t;

endpackage

FILE: rtl/polyline_path_interpolator_unit.sv
// ----------------------------------------------------------------------------
// polyline_path_interpolator_unit
// Pipelined 2D polyline interpolator over uniform segments.
// ----------------------------------------------------------------------------
// One transaction is accepted in every clock cycle; busy stays low. A query
// returns its result on out_data with out_valid high; loads return nothing.
// The path runs through the 32-stage restoring divider that forms the Q8.24
// fraction, one quotient bit per stage, followed by the index, path store
// read and two multiply stages.
// A load becomes visible to every query accepted after it. The receiver
// cannot stall, and the pipeline never stalls.
module polyline_path_interpolator_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ppi_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output logic              out_valid,
  output ppi_pkg::out_item_t out_data
);
  import ppi_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int PW   = TimeW + CW + 1;
  localparam int AGW  = PW - 1;
  localparam int HW   = AGW - FracBits;
  localparam int DW   = CoordW + 1;
  localparam int LW   = FracBits + DW;
  localparam int HPW  = HW + DW;
  localparam int PNW  = HPW + 1;
  localparam int RW   = PNW + 2;
  localparam int SH   = QuotW - FracBits;
  localparam int StF  = 4 + QuotW;
  localparam int StM  = StF + 1;
  localparam int StI  = StF + 2;
  localparam int StG  = StF + 3;
  localparam int NS   = StF + 9;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               point_index;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     clip;
  } side_t;

  typedef struct packed {
    logic [QuotW:0]   rem;
    logic [QuotW:0]   ad;
    logic [QuotW-1:0] dlo;
    logic [QuotW-1:0] q;
    logic             ovf;
    logic             neg;
    logic             dz;
  } div_t;

  function automatic div_t div_step(div_t a);
    logic [QuotW+1:0] trial;
    logic [QuotW+1:0] diff;
    div_t             r;
    r     = a;
    trial = {a.rem, a.dlo[QuotW-1]};
    diff  = trial - {1'b0, a.ad};
    r.dlo = {a.dlo[QuotW-2:0], 1'b0};
    if (!diff[QuotW+1]) begin
      r.rem = diff[QuotW:0];
      r.q   = {a.q[QuotW-2:0], 1'b1};
    end else begin
      r.rem = trial[QuotW:0];
      r.q   = {a.q[QuotW-2:0], 1'b0};
    end
    return r;
  endfunction

  // configuration
  logic [8:0]              cnt_r;
  logic signed [TimeW-1:0] ivs_r;
  logic signed [TimeW-1:0] ive_r;
  logic [CW-1:0]           n_w;
  logic [CW-1:0]           nm1_w;
  logic [CW-1:0]           nm2_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ivs_r <= '0;
      ive_r <= EndResetS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT:    cnt_r <= cfg_wdata[8:0];
        CFG_INTERVAL_START: ivs_r <= cfg_wdata;
        CFG_INTERVAL_END:   ive_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_w   = (32'(cnt_r) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cnt_r);
  assign nm1_w = n_w - CW'(1);
  assign nm2_w = n_w - CW'(2);

  // valid and side-band pipeline
  logic [NS:1] vld_r;
  side_t       side_r [1:StI];
  logic        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r[1] <= accept;
      for (int k = 2; k <= NS; k++) begin
        if (k == StG) begin
          vld_r[k] <= vld_r[k-1] && (side_r[StI].kind == KIND_QUERY);
        end else begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= '{kind: in_data.kind, point_index: in_data.point_index,
                   point_x: in_data.point_x, point_y: in_data.point_y,
                   clip: in_data.clip};
    for (int k = 2; k <= StI; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // stages 1-3: numerator, denominator, magnitudes, overflow
  logic signed [TimeW:0] num_r, den_r;
  logic [TimeW:0]        an_r, ad_r;
  logic                  neg_r, dz_r;
  div_t                  dv_r [QuotW+1];

  always_ff @(posedge clk) begin
    num_r <= $signed({in_data.query_time[TimeW-1], in_data.query_time})
           - $signed({ivs_r[TimeW-1], ivs_r});
    den_r <= $signed({ive_r[TimeW-1], ive_r}) - $signed({ivs_r[TimeW-1], ivs_r});
    an_r  <= num_r[TimeW] ? (TimeW+1)'(-num_r) : (TimeW+1)'(num_r);
    ad_r  <= den_r[TimeW] ? (TimeW+1)'(-den_r) : (TimeW+1)'(den_r);
    neg_r <= num_r[TimeW] ^ den_r[TimeW];
    dz_r  <= (den_r == '0);
    dv_r[0].rem <= (QuotW+1)'(an_r >> SH);
    dv_r[0].ad  <= ad_r;
    dv_r[0].dlo <= {an_r[SH-1:0], {FracBits{1'b0}}};
    dv_r[0].q   <= '0;
    dv_r[0].ovf <= ({{SH{1'b0}}, an_r} >= {ad_r, {SH{1'b0}}});
    dv_r[0].neg <= neg_r;
    dv_r[0].dz  <= dz_r;
  end

  // divider: one quotient bit per stage
  for (genvar j = 0; j < QuotW; j++) begin : g_div
    always_ff @(posedge clk) begin
      dv_r[j+1] <= div_step(dv_r[j]);
    end
  end

  // fraction, product, segment select
  logic signed [TimeW-1:0] f_nxt, f_r;
  logic signed [PW-1:0]    prod_r;
  logic                    fz_r, fneg_r, fone_r, fgt_r;
  logic [IW-1:0]           idx_nxt, idx_r;
  gmode_t                  mode_nxt, mode_r;
  logic signed [PW-1:0]    prodi_r;
  logic                    empi_r;

  always_comb begin
    if (dv_r[QuotW].dz) begin
      f_nxt = '0;
    end else if (!dv_r[QuotW].neg) begin
      f_nxt = (dv_r[QuotW].ovf || dv_r[QuotW].q[QuotW-1]) ? FracMaxU : dv_r[QuotW].q;
    end else begin
      f_nxt = (dv_r[QuotW].ovf || dv_r[QuotW].q > FracMinU) ? FracMinU : -dv_r[QuotW].q;
    end
  end

  always_comb begin
    idx_nxt  = '0;
    mode_nxt = G_CALC;
    if (n_w == CW'(1) || fz_r || (fneg_r && side_r[StM].clip)) begin
      mode_nxt = G_ZERO;
    end else if (fone_r || (fgt_r && side_r[StM].clip)) begin
      mode_nxt = G_ONE;
      idx_nxt  = IW'(nm2_w);
    end else if (fneg_r) begin
      idx_nxt = '0;
    end else if (fgt_r) begin
      idx_nxt = IW'(nm2_w);
    end else begin
      idx_nxt = prod_r[FracBits +: IW];
    end
  end

  always_ff @(posedge clk) begin
    f_r     <= f_nxt;
    prod_r  <= PW'(f_r) * $signed(PW'(nm1_w));
    fz_r    <= (f_r == '0);
    fneg_r  <= f_r[TimeW-1];
    fone_r  <= (f_r == FracOneS);
    fgt_r   <= (f_r > FracOneS);
    idx_r   <= idx_nxt;
    mode_r  <= mode_nxt;
    prodi_r <= prod_r;
    empi_r  <= (n_w == '0);
  end

  // path store, one copy per read port
  logic [2*CoordW-1:0] mema_r [MAX_POINTS];
  logic [2*CoordW-1:0] memb_r [MAX_POINTS];
  logic [2*CoordW-1:0] meme_r [MAX_POINTS];
  logic [2*CoordW-1:0] p0_r, p1_r, pe_r;
  logic                we_w;
  logic [IW-1:0]       waddr_w;
  logic [2*CoordW-1:0] wdata_w;

  assign we_w    = vld_r[StI] && (side_r[StI].kind == KIND_LOAD)
                && (32'(side_r[StI].point_index) < 32'(MAX_POINTS));
  assign waddr_w = IW'(side_r[StI].point_index);
  assign wdata_w = {side_r[StI].point_y, side_r[StI].point_x};

  always_ff @(posedge clk) begin
    if (we_w) begin
      mema_r[waddr_w] <= wdata_w;
    end
    p0_r <= mema_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (we_w) begin
      memb_r[waddr_w] <= wdata_w;
    end
    p1_r <= memb_r[idx_r + IW'(1)];
  end

  always_ff @(posedge clk) begin
    if (we_w) begin
      meme_r[waddr_w] <= wdata_w;
    end
    pe_r <= meme_r[IW'(nm1_w)];
  end

  // local fraction
  logic signed [PW-1:0] g_nxt, g_r;
  logic                 empg_r;

  always_comb begin
    case (mode_r)
      G_ZERO:  g_nxt = '0;
      G_ONE:   g_nxt = PW'(FracOneS);
      G_CALC:  g_nxt = prodi_r - $signed(PW'({idx_r, {FracBits{1'b0}}}));
      default: g_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    g_r    <= g_nxt;
    empg_r <= empi_r;
  end

  // interpolation lanes, x and y
  logic [AGW-1:0]           agd_r, aga_r;
  logic                     gngd_r;
  logic signed [CoordW-1:0] sd_r [2];
  logic signed [CoordW-1:0] sa_r [2];
  logic signed [CoordW-1:0] sp_r [2];
  logic signed [CoordW-1:0] ss_r [2];
  logic signed [DW-1:0]     dd_r [2];
  logic [DW-1:0]            ada_r [2];
  logic                     nga_r [2];
  logic                     ngp_r [2];
  logic                     ngs_r [2];
  logic                     ngr_r [2];
  logic [LW-1:0]            lop_r [2];
  logic [HPW-1:0]           hip_r [2];
  logic [PNW-1:0]           pints_r [2];
  logic                     pfs_r [2];
  logic                     pfr_r [2];
  logic signed [RW-1:0]     rr_r [2];
  logic [2*CoordW-1:0]      ed_r, ea_r, ep_r, es_r, er_r;
  logic                     empd_r, empa_r, empp_r, emps_r, empr_r;

  always_ff @(posedge clk) begin
    agd_r  <= g_r[PW-1] ? AGW'(-g_r) : AGW'(g_r);
    gngd_r <= g_r[PW-1];
    ed_r   <= pe_r;
    empd_r <= empg_r;
    aga_r  <= agd_r;
    ea_r   <= ed_r;
    empa_r <= empd_r;
    ep_r   <= ea_r;
    empp_r <= empa_r;
    es_r   <= ep_r;
    emps_r <= empp_r;
    er_r   <= es_r;
    empr_r <= emps_r;
    sa_r   <= sd_r;
    sp_r   <= sa_r;
    ss_r   <= sp_r;
    ngp_r  <= nga_r;
    ngs_r  <= ngp_r;
    ngr_r  <= ngs_r;
    pfr_r  <= pfs_r;
    for (int a = 0; a < 2; a++) begin
      sd_r[a]    <= p0_r[a*CoordW +: CoordW];
      dd_r[a]    <= DW'($signed(p1_r[a*CoordW +: CoordW]))
                  - DW'($signed(p0_r[a*CoordW +: CoordW]));
      ada_r[a]   <= dd_r[a][DW-1] ? DW'(-dd_r[a]) : DW'(dd_r[a]);
      nga_r[a]   <= gngd_r ^ dd_r[a][DW-1];
      lop_r[a]   <= LW'(aga_r[FracBits-1:0]) * LW'(ada_r[a]);
      hip_r[a]   <= HPW'(aga_r[AGW-1:FracBits]) * HPW'(ada_r[a]);
      pints_r[a] <= PNW'(hip_r[a]) + PNW'(lop_r[a][LW-1:FracBits]);
      pfs_r[a]   <= |lop_r[a][FracBits-1:0];
      rr_r[a]    <= ngs_r[a] ? RW'(ss_r[a]) - $signed(RW'(pints_r[a]))
                             : RW'(ss_r[a]) + $signed(RW'(pints_r[a]));
    end
  end

  // truncation toward zero and saturation
  logic signed [RW-1:0]     adj_w [2];
  logic signed [CoordW-1:0] sat_w [2];
  out_item_t                od_r;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      adj_w[a] = rr_r[a];
      if (!ngr_r[a] && rr_r[a] < 0 && pfr_r[a]) begin
        adj_w[a] = rr_r[a] + RW'(1);
      end else if (ngr_r[a] && rr_r[a] > 0 && pfr_r[a]) begin
        adj_w[a] = rr_r[a] - RW'(1);
      end
      if (adj_w[a] > RW'(CoordMax)) begin
        sat_w[a] = CoordW'(CoordMax);
      end else if (adj_w[a] < RW'(CoordMin)) begin
        sat_w[a] = CoordW'(CoordMin);
      end else begin
        sat_w[a] = adj_w[a][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r.pos_x <= empr_r ? '0 : sat_w[0];
    od_r.pos_y <= empr_r ? '0 : sat_w[1];
    od_r.end_x <= empr_r ? '0 : er_r[CoordW-1:0];
    od_r.end_y <= empr_r ? '0 : er_r[2*CoordW-1:CoordW];
  end

  assign out_valid = vld_r[NS];
  assign out_data  = od_r;

  // checks
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.kind == KIND_QUERY, NS))
    else $error("result without a query transaction");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[StF-1] && !dv_r[QuotW].ovf |-> dv_r[QuotW].rem < dv_r[QuotW].ad)
    else $error("divider remainder not below divisor");

  a_frac_sat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[StF] && $past(!dv_r[QuotW].dz && dv_r[QuotW].ovf)
      |-> f_r == FracMaxU || f_r == FracMinU)
    else $error("fraction overflow not saturated");

endmodule
